>>> hdl/cts_pkg.sv
// ============================================================================
// cts_pkg - shared types and codes for the cooperative task scheduler
// Command and result beat layouts, slot record layout, status and error codes.
// ============================================================================
package cts_pkg;

    localparam int DEF_NUM_SLOTS = 4;
    localparam int MAX_OUT       = 4;   // results per dispatch command

    // command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_DISP = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_NONE  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    // sticky error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
    localparam logic [1:0] ERR_NO_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  task_handle;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
        logic [2:0]  slot_select;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot_out;
        logic [7:0] handle_out;
        logic       last_of_run;
        logic [1:0] sticky_error;
    } t_result;

    typedef struct packed {
        logic [7:0]  handle;
        logic [16:0] delay;
        logic [15:0] period;
        logic [7:0]  run_count;
    } t_slot_rec;

endpackage

>>> hdl/cooperative_task_scheduler.sv
// ============================================================================
// cooperative_task_scheduler - time-triggered cooperative task scheduler
// Slot table in a synchronous memory, scanned one slot per cycle for tick,
// dispatch and free-slot search; valid marks and sticky error in flops.
// ============================================================================
//
//  channel   ports                           handshake
//  --------  ------------------------------  ----------------------------------
//  command   i_cmd (t_cmd_in)                taken when start && !busy
//  result    o_result (t_result)             one beat per cycle of o_result_stb
//
//  Cycles: delete finishes at the accepting edge, busy never rises, and its
//  beat shows in the next cycle. Add walks the valid marks one slot a cycle.
//  Tick and dispatch stream every slot through the memory read/modify/write
//  loop through the single read port. Reset is synchronous and clears all
//  valid marks and the error register at once; no clearing pass. The
//  receiver cannot stall: each beat is on o_result for one cycle only.
//
module cooperative_task_scheduler
    import cts_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd_in i_cmd,
    output logic    o_result_stb,
    output t_result o_result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int EXT_W  = (CNT_W > 3) ? CNT_W : 3;
    localparam int HIT_W  = $clog2(MAX_OUT + 1);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(NUM_SLOTS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // slot table: one record per slot, no reset, gated by r_valid
    t_slot_rec r_mem [NUM_SLOTS];
    t_slot_rec r_rd_data;

    logic [2:0]           r_state, n_state;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic                 r_p_vld, n_p_vld;
    logic [SLOT_W-1:0]    r_p_idx, n_p_idx;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [1:0]           r_err, n_err;
    logic                 r_out_stb, n_out_stb;
    t_result              r_out, n_out;
    t_cmd_in              r_cmd, n_cmd;
    logic                 r_pend, n_pend;
    logic [2:0]           r_pend_slot, n_pend_slot;
    logic [7:0]           r_pend_handle, n_pend_handle;
    logic [HIT_W-1:0]     r_hits, n_hits;

    logic                 rd_en;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wa;
    t_slot_rec            mem_wd;

    logic [EXT_W-1:0]     sel_ext;
    logic [SLOT_W-1:0]    sel_idx;
    logic [16:0]          dly_dec;

    assign sel_ext = EXT_W'(i_cmd.slot_select);
    assign sel_idx = sel_ext[SLOT_W-1:0];
    assign dly_dec = r_rd_data.delay - 17'd1;

    assign busy         = (r_state != S_IDLE);
    assign o_result_stb = r_out_stb;
    assign o_result     = r_out;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_p_vld       = 1'b0;
        n_p_idx       = r_p_idx;
        n_valid       = r_valid;
        n_err         = r_err;
        n_out_stb     = 1'b0;
        n_out         = r_out;
        n_cmd         = r_cmd;
        n_pend        = r_pend;
        n_pend_slot   = r_pend_slot;
        n_pend_handle = r_pend_handle;
        n_hits        = r_hits;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = r_p_idx;
        mem_wd        = r_rd_data;

        // modify stage: the record of slot r_p_idx arrived from the memory
        if (r_p_vld && r_valid[r_p_idx]) begin
            case (r_cmd.command)
                CMD_TICK: begin
                    // a fired one-shot holds at zero
                    if (r_rd_data.delay != 17'd0) begin
                        mem_we       = 1'b1;
                        mem_wd.delay = dly_dec;
                        if (dly_dec == 17'd0) begin
                            if (r_rd_data.run_count != 8'hFF) begin
                                mem_wd.run_count = r_rd_data.run_count + 8'd1;
                            end
                            if (r_rd_data.period != 16'd0) begin
                                mem_wd.delay = {1'b0, r_rd_data.period};
                            end
                        end
                    end
                end
                CMD_DISP: begin
                    if (r_rd_data.run_count != 8'd0 && r_hits < HIT_W'(MAX_OUT)) begin
                        mem_we           = 1'b1;
                        mem_wd.run_count = r_rd_data.run_count - 8'd1;
                        if (r_rd_data.period == 16'd0) begin
                            n_valid[r_p_idx] = 1'b0;   // drop the one-shot
                        end
                        // release the held hit; this one may be the last
                        if (r_pend) begin
                            n_out_stb = 1'b1;
                            n_out     = '{ST_OK, r_pend_slot, r_pend_handle, 1'b0, r_err};
                        end
                        n_pend        = 1'b1;
                        n_pend_slot   = 3'(r_p_idx);
                        n_pend_handle = r_rd_data.handle;
                        n_hits        = r_hits + HIT_W'(1);
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_idx  = '0;
                    n_hits = '0;
                    n_pend = 1'b0;
                    case (i_cmd.command)
                        CMD_ADD: n_state = S_ADD;
                        CMD_DEL: begin
                            n_out_stb = 1'b1;
                            if (sel_ext >= EXT_W'(NUM_SLOTS)) begin
                                n_err = ERR_NO_DELETE;
                                n_out = '{ST_BAD, i_cmd.slot_select, 8'd0, 1'b1,
                                          ERR_NO_DELETE};
                            end else if (!r_valid[sel_idx]) begin
                                n_err = ERR_NO_DELETE;
                                n_out = '{ST_EMPTY, i_cmd.slot_select, 8'd0, 1'b1,
                                          ERR_NO_DELETE};
                            end else begin
                                n_valid[sel_idx] = 1'b0;
                                n_out = '{ST_OK, i_cmd.slot_select, 8'd0, 1'b1, r_err};
                            end
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end
            S_ADD: begin
                if (!r_valid[r_idx]) begin
                    mem_we    = 1'b1;
                    mem_wa    = r_idx;
                    mem_wd    = '{r_cmd.task_handle, 17'(r_cmd.start_delay) + 17'd1,
                                  r_cmd.repeat_period, 8'd0};
                    n_valid[r_idx] = 1'b1;
                    n_out_stb = 1'b1;
                    n_out     = '{ST_OK, 3'(r_idx), 8'd0, 1'b1, r_err};
                    n_state   = S_IDLE;
                end else if (r_idx == LAST) begin
                    n_err     = ERR_TOO_MANY;
                    n_out_stb = 1'b1;
                    n_out     = '{ST_FULL, 3'(NUM_SLOTS), 8'd0, 1'b1, ERR_TOO_MANY};
                    n_state   = S_IDLE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_SCAN: begin
                // issue one slot read per cycle
                rd_en   = 1'b1;
                n_p_vld = 1'b1;
                n_p_idx = r_idx;
                if (r_idx == LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_DRAIN: n_state = S_FIN;
            S_FIN: begin
                n_out_stb = 1'b1;
                n_state   = S_IDLE;
                n_pend    = 1'b0;
                if (r_cmd.command == CMD_DISP) begin
                    if (r_pend) begin
                        n_out = '{ST_OK, r_pend_slot, r_pend_handle, 1'b1, r_err};
                    end else begin
                        n_out = '{ST_NONE, 3'd0, 8'd0, 1'b1, r_err};
                    end
                end else begin
                    n_out = '{ST_OK, 3'd0, 8'd0, 1'b1, r_err};
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // slot memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p_vld   <= 1'b0;
            r_valid   <= '0;
            r_err     <= ERR_NONE;
            r_out_stb <= 1'b0;
            r_pend    <= 1'b0;
            r_hits    <= '0;
        end else begin
            r_state   <= n_state;
            r_p_vld   <= n_p_vld;
            r_valid   <= n_valid;
            r_err     <= n_err;
            r_out_stb <= n_out_stb;
            r_pend    <= n_pend;
            r_hits    <= n_hits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_p_idx       <= n_p_idx;
        r_out         <= n_out;
        r_cmd         <= n_cmd;
        r_pend_slot   <= n_pend_slot;
        r_pend_handle <= n_pend_handle;
    end

`ifndef SYNTH
    a_idle_no_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_p_vld)
        else $error("slot update pending while idle");

    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= HIT_W'(MAX_OUT))
        else $error("dispatch emitted too many beats");

    a_delete_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.command == CMD_DEL) |=> o_result_stb)
        else $error("delete produced no beat");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_stb && !o_result.last_of_run) |-> busy)
        else $error("non-final beat with the command already finished");
`endif

endmodule
